// File: rtl/lss_pkg.sv
package lss_pkg;

   localparam int LSS_DEPTH = 128;
   localparam int WORD_W    = 32;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int FIELD8_W  = 8;

   localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
   localparam logic [OP_W-1:0] OP_POP   = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
   localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   localparam logic signed [WORD_W-1:0]   NEG_ONE_WORD = -32'sd1;
   localparam logic signed [FIELD8_W-1:0] NEG_ONE_POS  = -8'sd1;

   // shift controls broadcast to every cell of the chain
   typedef struct packed {
      logic push;   // take the word from the neighbor above
      logic pull;   // take the word from the neighbor below
   } cell_ctl_type;

   typedef struct packed {
      logic start;
      logic run;
   } scan_ctl_type;

endpackage

// File: rtl/lss_cell.sv
module lss_cell
   import lss_pkg::*;
(
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic signed [WORD_W-1:0] up_data,
   input  logic signed [WORD_W-1:0] down_data,
   output logic signed [WORD_W-1:0] data
);

   logic signed [WORD_W-1:0] data_ff;

   // push and pull never rise together; with neither, hold the word
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         data_ff <= up_data;
      end else if (ctl.pull) begin
         data_ff <= down_data;
      end
   end

   assign data = data_ff;

endmodule

// File: rtl/lss_scan.sv
module lss_scan
   import lss_pkg::*;
#(
   parameter int DEPTH = LSS_DEPTH
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  scan_ctl_type                   ctl,
   input  logic signed [WORD_W-1:0]       target,
   input  logic signed [WORD_W-1:0]       head,
   input  logic [$clog2(DEPTH+1)-1:0]     fill,
   output logic                           last,
   output logic [$clog2(DEPTH+1)-1:0]     count,
   output logic                           found,
   output logic [$clog2(DEPTH)-1:0]       pos
);

   localparam int LVL_W = $clog2(DEPTH+1);
   localparam int IDX_W = $clog2(DEPTH);

   logic signed [WORD_W-1:0] target_ff;
   logic [IDX_W-1:0]         step_ff;
   logic [LVL_W-1:0]         count_ff;
   logic                     found_ff;
   logic [IDX_W-1:0]         pos_ff;
   logic                     hit;

   // the word at the head is the one step_ff places below the top
   assign hit  = (head == target_ff) && (LVL_W'(step_ff) < fill);
   assign last = (step_ff == IDX_W'(DEPTH-1));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         found_ff <= 1'b0;
         count_ff <= '0;
      end else if (ctl.start) begin
         step_ff  <= '0;
         found_ff <= 1'b0;
         count_ff <= '0;
         target_ff <= target;
      end else if (ctl.run) begin
         step_ff <= step_ff + IDX_W'(1);
         if (hit) begin
            count_ff <= count_ff + LVL_W'(1);
         end
         if (hit && !found_ff) begin
            found_ff <= 1'b1;
            pos_ff   <= step_ff;
         end
      end
   end

   assign count = count_ff;
   assign found = found_ff;
   assign pos   = pos_ff;

endmodule

// File: rtl/lifo_stack_with_search_core.sv
// LIFO stack of signed 32-bit words with count and find.
// Input channel req_*: req_op selects push, pop, peek, count equal or
// find first; req_value is the word to push or to look for. Every
// accepted word yields exactly one result word on rsp_*.
// The stack is a chain of DEPTH cells with the top in cell 0; push shifts
// the chain down, pop shifts it up.
// Push, pop, peek and unused op codes: result registered in the cycle after
// accept, one item per cycle while rsp_ready stays high.
// Count and find: the chain rotates once through a single comparator at
// the head in state S_SCAN, then S_DONE loads the result register once the
// result register is free. The rotation leaves the stack as it was.
// A new item is taken only when the block is idle and the result register
// is empty or being read in the same cycle; while rsp_ready is low the
// result holds and req_ready drops.
// Reset (synchronous, active high) empties the stack and drops rsp_valid;
// stored words are not cleared.
module lifo_stack_with_search_core
   import lss_pkg::*;
#(
   parameter int DEPTH = LSS_DEPTH
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_W-1:0]   rsp_read_value,
   output logic [FIELD8_W-1:0]        rsp_match_count,
   output logic signed [FIELD8_W-1:0] rsp_match_position
);

   localparam int LVL_W = $clog2(DEPTH+1);
   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type                  state_ff;
   logic [LVL_W-1:0]           fill_ff;
   logic [OP_W-1:0]            op_ff;
   logic                       rsp_valid_ff;
   logic [STATUS_W-1:0]        rsp_status_ff;
   logic signed [WORD_W-1:0]   rsp_read_value_ff;
   logic [FIELD8_W-1:0]        rsp_match_count_ff;
   logic signed [FIELD8_W-1:0] rsp_match_position_ff;

   logic                       accept;
   logic                       out_free;
   logic                       is_full;
   logic                       is_empty;
   cell_ctl_type               cell_ctl;
   scan_ctl_type               scan_ctl;
   logic signed [WORD_W-1:0]   cell_data [DEPTH];
   logic                       scan_last;
   logic [LVL_W-1:0]           scan_count;
   logic                       scan_found;
   logic [IDX_W-1:0]           scan_pos;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign is_full   = (fill_ff == LVL_W'(DEPTH));
   assign is_empty  = (fill_ff == '0);

   always_comb begin
      cell_ctl.push  = accept && (req_op == OP_PUSH) && !is_full;
      // scan rotates the chain through the head with the same up shift
      cell_ctl.pull  = (accept && (req_op == OP_POP) && !is_empty) ||
                       (state_ff == S_SCAN);
      scan_ctl.start = accept && ((req_op == OP_COUNT) || (req_op == OP_FIND));
      scan_ctl.run   = (state_ff == S_SCAN);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_W-1:0] up_word;
      logic signed [WORD_W-1:0] down_word;

      if (i == 0) begin : g_top
         assign up_word = req_value;
      end else begin : g_mid
         assign up_word = cell_data[i-1];
      end
      if (i == DEPTH-1) begin : g_wrap
         assign down_word = cell_data[0];
      end else begin : g_link
         assign down_word = cell_data[i+1];
      end

      lss_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .up_data   (up_word),
         .down_data (down_word),
         .data      (cell_data[i])
      );
   end

   lss_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctl    (scan_ctl),
      .target (req_value),
      .head   (cell_data[0]),
      .fill   (fill_ff),
      .last   (scan_last),
      .count  (scan_count),
      .found  (scan_found),
      .pos    (scan_pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_op)
                     OP_PUSH: begin
                        rsp_valid_ff          <= 1'b1;
                        rsp_read_value_ff     <= '0;
                        rsp_match_count_ff    <= '0;
                        rsp_match_position_ff <= '0;
                        if (is_full) begin
                           rsp_status_ff <= STATUS_FULL;
                        end else begin
                           rsp_status_ff <= STATUS_OK;
                           fill_ff       <= fill_ff + LVL_W'(1);
                        end
                     end
                     OP_POP, OP_PEEK: begin
                        rsp_valid_ff          <= 1'b1;
                        rsp_match_count_ff    <= '0;
                        rsp_match_position_ff <= '0;
                        if (is_empty) begin
                           rsp_status_ff     <= STATUS_EMPTY;
                           rsp_read_value_ff <= NEG_ONE_WORD;
                        end else begin
                           rsp_status_ff     <= STATUS_OK;
                           rsp_read_value_ff <= cell_data[0];
                           if (req_op == OP_POP) begin
                              fill_ff <= fill_ff - LVL_W'(1);
                           end
                        end
                     end
                     OP_COUNT, OP_FIND: begin
                        // hold the result until the rotation completes
                        rsp_valid_ff <= 1'b0;
                        op_ff        <= req_op;
                        state_ff     <= S_SCAN;
                     end
                     default: begin
                        rsp_valid_ff          <= 1'b1;
                        rsp_status_ff         <= STATUS_OK;
                        rsp_read_value_ff     <= '0;
                        rsp_match_count_ff    <= '0;
                        rsp_match_position_ff <= '0;
                     end
                  endcase
               end else if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               if (scan_last) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_read_value_ff <= '0;
                  state_ff          <= S_IDLE;
                  if (op_ff == OP_FIND) begin
                     rsp_match_count_ff <= '0;
                     if (scan_found) begin
                        rsp_status_ff         <= STATUS_OK;
                        rsp_match_position_ff <= FIELD8_W'(scan_pos);
                     end else begin
                        rsp_status_ff         <= STATUS_NOTFOUND;
                        rsp_match_position_ff <= NEG_ONE_POS;
                     end
                  end else begin
                     rsp_status_ff         <= STATUS_OK;
                     rsp_match_count_ff    <= FIELD8_W'(scan_count);
                     rsp_match_position_ff <= '0;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_match_count    = rsp_match_count_ff;
   assign rsp_match_position = rsp_match_position_ff;

endmodule

// File: rtl/lss_checker.sv
module lss_checker
   import lss_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [OP_W-1:0]            req_op,
   input logic signed [WORD_W-1:0]   req_value,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [STATUS_W-1:0]        rsp_status,
   input logic signed [WORD_W-1:0]   rsp_read_value,
   input logic [FIELD8_W-1:0]        rsp_match_count,
   input logic signed [FIELD8_W-1:0] rsp_match_position
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_read_value))
      else $error("stalled result word changed or dropped");

   a_fast_op_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_op == OP_PUSH || req_op == OP_POP || req_op == OP_PEEK)
      |=> rsp_valid)
      else $error("push, pop or peek result not ready next cycle");

   a_empty_reads_neg_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_read_value == NEG_ONE_WORD)
      else $error("empty status without -1 read value");

   a_notfound_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NOTFOUND |->
      rsp_match_position == NEG_ONE_POS)
      else $error("not-found status without -1 position");

endmodule

bind lifo_stack_with_search_core lss_checker u_lss_checker (.*);
